// ===== hdl/lpr_pkg.sv =====
// shared types and constants of the line pixel rasterizer
package lpr_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int COORD_W     = 7;
  localparam int IN_W        = 8;
  localparam int ERR_W       = 9;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic step;
  } lpr_cmd_t;

  typedef struct packed {
    logic last;
  } lpr_sts_t;

endpackage

// ===== hdl/lpr_ctrl.sv =====
// controller state machine of the line walk
module lpr_ctrl import lpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  lpr_sts_t sts,
  output lpr_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;
  logic take;

  assign out_valid = (state_r == S_EMIT);
  assign in_stall  = !((state_r == S_IDLE) || (!out_stall && sts.last));
  assign take      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (sts.last) begin
            if (take) begin
              cmd.load = 1'b1;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lpr_datapath.sv =====
// datapath of the line walk: range check, walk registers and error term
module lpr_datapath import lpr_pkg::*; #(
  parameter int IMG_SIZE = 64
) (
  input  logic            clk,
  input  logic [IN_W-1:0] start_x,
  input  logic [IN_W-1:0] start_y,
  input  logic [IN_W-1:0] end_x,
  input  logic [IN_W-1:0] end_y,
  input  lpr_cmd_t        cmd,
  output lpr_sts_t        sts,
  output coord_t          pixel_x,
  output coord_t          pixel_y,
  output logic            last_pixel,
  output logic            rejected
);

  localparam logic [IN_W-1:0] IMG_LIM = IN_W'(IMG_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  coord_t                  cur_x_r, cur_y_r, goal_x_r, goal_y_r, span_x_r, span_y_r;
  logic                    step_x_neg_r, step_y_neg_r, rej_r;
  logic signed [ERR_W-1:0] err_r;
  logic [CNT_W-1:0]        cnt_r;

  logic                    in_ok;
  coord_t                  ax, ay, bx, by, dx, dy;
  logic signed [ERR_W:0]   e2, neg_dy, dx_w, err_w;
  logic                    step_x, step_y, at_goal;

  function automatic logic in_rng(input logic [IN_W-1:0] v);
    return !v[IN_W-1] && ({1'b0, v[COORD_W-1:0]} < IMG_LIM);
  endfunction

  always_comb begin
    in_ok = in_rng(start_x) && in_rng(start_y) && in_rng(end_x) && in_rng(end_y);
    ax = start_x[COORD_W-1:0];
    ay = start_y[COORD_W-1:0];
    bx = end_x[COORD_W-1:0];
    by = end_y[COORD_W-1:0];
    dx = (bx > ax) ? bx - ax : ax - bx;
    dy = (by > ay) ? by - ay : ay - by;
  end

  always_comb begin
    e2     = {err_r, 1'b0};
    dx_w   = $signed({3'b000, span_x_r});
    neg_dy = -$signed({3'b000, span_y_r});
    step_x = e2 > neg_dy;
    step_y = e2 < dx_w;
    err_w  = {err_r[ERR_W-1], err_r};
    if (step_x) err_w = err_w + neg_dy;
    if (step_y) err_w = err_w + dx_w;
  end

  assign at_goal    = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
  assign sts.last   = rej_r || at_goal || (cnt_r == CNT_LAST);
  assign pixel_x    = cur_x_r;
  assign pixel_y    = cur_y_r;
  assign last_pixel = sts.last;
  assign rejected   = rej_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r <= '0;
      if (in_ok) begin
        rej_r        <= 1'b0;
        cur_x_r      <= ax;
        cur_y_r      <= ay;
        goal_x_r     <= bx;
        goal_y_r     <= by;
        span_x_r     <= dx;
        span_y_r     <= dy;
        step_x_neg_r <= !(ax < bx);
        step_y_neg_r <= !(ay < by);
        err_r        <= $signed({2'b00, dx}) - $signed({2'b00, dy});
      end else begin
        rej_r   <= 1'b1;
        cur_x_r <= '0;
        cur_y_r <= '0;
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      err_r <= err_w[ERR_W-1:0];
      if (step_x) cur_x_r <= step_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      if (step_y) cur_y_r <= step_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

endmodule

// ===== hdl/line_pixel_rasterizer.sv =====
// line pixel rasterizer top level
// the first pixel is shown in the cycle after the segment transfer
// one pixel per cycle from the walk registers while out_stall is low; a segment gives
//   max(|dx|,|dy|)+1 pixels (at most 64), a rejected segment one result
// the next segment is taken in the cycle of the last pixel transfer
// reset: synchronous active-low rst_n returns the controller to idle
module line_pixel_rasterizer import lpr_pkg::*; #(
  parameter int IMG_SIZE = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IN_W-1:0] in_start_x,
  input  logic [IN_W-1:0] in_start_y,
  input  logic [IN_W-1:0] in_end_x,
  input  logic [IN_W-1:0] in_end_y,
  output logic            out_valid,
  input  logic            out_stall,
  output coord_t          out_pixel_x,
  output coord_t          out_pixel_y,
  output logic            out_last_pixel,
  output logic            out_rejected
);

  lpr_cmd_t cmd;
  lpr_sts_t sts;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpr_datapath #(
    .IMG_SIZE (IMG_SIZE)
  ) u_datapath (
    .clk        (clk),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .last_pixel (out_last_pixel),
    .rejected   (out_rejected)
  );

`ifndef SYNTHESIS
  a_in_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!out_valid || (!out_stall && out_last_pixel)))
    else $error("segment transfer while walk unfinished");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |->
      (out_last_pixel && out_pixel_x == '0 && out_pixel_y == '0))
    else $error("malformed rejected result");

  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_pixel) |=> out_valid)
    else $error("walk stopped before last pixel");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_pixel && !in_valid) |=> !out_valid)
    else $error("result without segment transfer");
`endif

endmodule

// ===== bench/tb_line_pixel_rasterizer.sv =====
// self-checking bench for the line pixel rasterizer: segment walks checked pixel by pixel
module tb_line_pixel_rasterizer;
  import lpr_pkg::*;

  localparam int IMG        = 64;
  localparam int HOLD_LEN   = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 60;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
    logic   rej;
  } pixel_t;

  class segment_pixel_book;
    pixel_t pixels_due[$];
    int     fails;
    coord_t walk_x, walk_y, goal_x, goal_y, span_x, span_y;
    bit     x_down, y_down, walking;
    logic signed [ERR_W-1:0] walk_err;

    function new();
      fails   = 0;
      walk_x  = '0; walk_y = '0; goal_x = '0; goal_y = '0;
      span_x  = '0; span_y = '0;
      x_down  = 1'b0; y_down = 1'b0; walking = 1'b0;
      walk_err = '0;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function bit on_canvas(int v);
      return v >= 0 && v < IMG;
    endfunction

    function void due(int x, int y, logic last, logic rej);
      pixel_t p;
      p.x    = coord_t'(x);
      p.y    = coord_t'(y);
      p.last = last;
      p.rej  = rej;
      pixels_due.push_back(p);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fails++;
    endtask

    // integer error-term walk of one accepted segment
    function void take_segment(logic [IN_W-1:0] sx_in, logic [IN_W-1:0] sy_in,
                               logic [IN_W-1:0] ex_in, logic [IN_W-1:0] ey_in);
      int ax, ay, bx, by, x, y, dx, dy, ix, iy, err, e2, n;
      ax = $signed(sx_in);
      ay = $signed(sy_in);
      bx = $signed(ex_in);
      by = $signed(ey_in);
      if (!on_canvas(ax) || !on_canvas(ay) || !on_canvas(bx) || !on_canvas(by)) begin
        due(0, 0, 1'b1, 1'b1);
        return;
      end
      dx  = (bx > ax) ? bx - ax : ax - bx;
      dy  = (by > ay) ? by - ay : ay - by;
      ix  = (ax < bx) ? 1 : -1;
      iy  = (ay < by) ? 1 : -1;
      err = dx - dy;
      x   = ax;
      y   = ay;
      goal_x  = coord_t'(bx);
      goal_y  = coord_t'(by);
      span_x  = coord_t'(dx);
      span_y  = coord_t'(dy);
      x_down  = (ix < 0);
      y_down  = (iy < 0);
      walking = 1'b1;
      n = 0;
      while ((x != bx || y != by) && n < MAX_RESULTS - 1) begin
        e2 = 2 * err;
        due(x, y, 1'b0, 1'b0);
        n++;
        if (e2 > -dy) begin
          err -= dy;
          x += ix;
        end
        if (e2 < dx) begin
          err += dx;
          y += iy;
        end
      end
      due(x, y, 1'b1, 1'b0);
      walk_x   = coord_t'(x);
      walk_y   = coord_t'(y);
      walk_err = ERR_W'(err);
      walking  = 1'b0;
    endfunction

    task check_pixel(coord_t px, coord_t py, logic last, logic rej);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) with nothing expected", px, py));
        return;
      end
      want = pixels_due.pop_front();
      if (px !== want.x)
        report($sformatf("pixel_x got %0d exp %0d", px, want.x));
      if (py !== want.y)
        report($sformatf("pixel_y got %0d exp %0d", py, want.y));
      if (last !== want.last)
        report($sformatf("last_pixel got %b exp %b at (%0d,%0d)", last, want.last,
                         want.x, want.y));
      if (rej !== want.rej)
        report($sformatf("rejected got %b exp %b at (%0d,%0d)", rej, want.rej,
                         want.x, want.y));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [IN_W-1:0] in_start_x = '0;
  logic [IN_W-1:0] in_start_y = '0;
  logic [IN_W-1:0] in_end_x = '0;
  logic [IN_W-1:0] in_end_y = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  coord_t          out_pixel_x;
  coord_t          out_pixel_y;
  logic            out_last_pixel;
  logic            out_rejected;

  segment_pixel_book book = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  line_pixel_rasterizer #(.IMG_SIZE(IMG)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel),
    .out_rejected   (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall, long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // both transfers sampled at the same edge, input first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        book.take_segment(in_start_x, in_start_y, in_end_x, in_end_y);
      if (out_valid && !out_stall)
        book.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel, out_rejected);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_segment(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                              input logic [IN_W-1:0] bx, input logic [IN_W-1:0] by);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= ax;
    in_start_y <= ay;
    in_end_x   <= bx;
    in_end_y   <= by;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_random_segment();
    int kind, k, j, v;
    logic [IN_W-1:0] c [4];
    kind = $urandom_range(99);
    for (k = 0; k < 4; k++)
      c[k] = IN_W'($urandom_range(IMG - 1));
    if (kind >= 65 && kind < 80) begin
      // short segment around the start
      for (j = 0; j < 2; j++) begin
        v = int'(c[j]) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > IMG - 1) v = IMG - 1;
        c[j + 2] = IN_W'(v);
      end
    end else if (kind >= 80 && kind < 90) begin
      k = $urandom_range(3);
      c[k] = $urandom_range(1) ? IN_W'($urandom_range(255, 128))
                               : IN_W'($urandom_range(127, IMG));
    end else if (kind >= 90) begin
      for (k = 0; k < 4; k++)
        c[k] = IN_W'($urandom_range(255));
    end
    send_segment(c[0], c[1], c[2], c[3]);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_segment(8'd0, 8'd0, 8'd0, 8'd0);
    send_segment(8'd63, 8'd63, 8'd63, 8'd63);
    send_segment(8'd0, 8'd0, 8'd63, 8'd0);
    send_segment(8'd63, 8'd5, 8'd0, 8'd5);
    send_segment(8'd7, 8'd0, 8'd7, 8'd63);
    send_segment(8'd9, 8'd63, 8'd9, 8'd0);
    send_segment(8'd0, 8'd0, 8'd63, 8'd63);
    send_segment(8'd63, 8'd0, 8'd0, 8'd63);
    send_segment(8'd0, 8'd0, 8'd63, 8'd10);
    send_segment(8'd3, 8'd60, 8'd10, 8'd1);
    send_segment(8'd40, 8'd20, 8'd2, 8'd30);
    send_segment(8'd50, 8'd50, 8'd45, 8'd1);
    send_segment(8'd10, 8'd10, 8'd11, 8'd11);
    send_segment(8'hFF, 8'd0, 8'd5, 8'd5);
    send_segment(8'd0, 8'h80, 8'd5, 8'd5);
    send_segment(8'd5, 8'd5, 8'd64, 8'd5);
    send_segment(8'd5, 8'd5, 8'd5, 8'h7F);
    send_segment(8'h7F, 8'd0, 8'd0, 8'd0);
    send_segment(8'd0, 8'd64, 8'd0, 8'd0);
    send_segment(8'd0, 8'd0, 8'hFF, 8'd0);
    send_segment(8'd0, 8'd0, 8'd0, 8'h80);
    send_segment(8'h80, 8'hFF, 8'h7F, 8'h40);
    drain_pixels();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 0;  rx_stall_pct = 0;
          hold_req = 1'b1;
        end
        1: begin
          tx_idle_pct = 78; rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;  rx_stall_pct = 78;
        end
        default: begin
          tx_idle_pct = 11; rx_stall_pct = 11;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_segment();
      drain_pixels();
    end

    repeat (100) @(posedge clk);
    if (book.fails == 0 && book.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
